// File: design/crbm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crbm_pkg
// Shared types, codes and constant tables for the cartridge bank mapper.
// ---------------------------------------------------------------------------
package crbm_pkg;

    // Default memory sizes in bytes.
    localparam int unsigned ROM_BYTES_DEF = 2097152;
    localparam int unsigned RAM_BYTES_DEF = 32768;

    // Banking geometry of the cartridge address map.
    localparam int unsigned ROM_BANKS      = 128;
    localparam int unsigned ROM_BANK_BYTES = 16384;
    localparam int unsigned RAM_BANKS      = 4;
    localparam int unsigned RAM_BANK_BYTES = 8192;

    // Widest physical index of each store.
    localparam int unsigned ROM_IDX_W = 21;
    localparam int unsigned RAM_IDX_W = 15;

    // CPU bus address map.
    localparam logic [15:0] ADDR_RAM_EN_LAST   = 16'h1FFF;
    localparam logic [15:0] ADDR_ROM_FIX_LAST  = 16'h3FFF;
    localparam logic [15:0] ADDR_ROM_BANK_LAST = 16'h7FFF;
    localparam logic [15:0] ADDR_RAM_SEL_LAST  = 16'h5FFF;
    localparam logic [15:0] ADDR_RAM_FIRST     = 16'hA000;
    localparam logic [15:0] ADDR_RAM_LAST      = 16'hBFFF;

    // Control write values.
    localparam logic [3:0] RAM_EN_KEY      = 4'hA;
    localparam logic [7:0] RAM_BANK_MAX    = 8'h03;
    localparam logic [7:0] UNMAPPED_BYTE   = 8'hFF;
    localparam logic [6:0] ROM_BANK_RESET  = 7'd1;

    // Kind of bus word.
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_LOAD  = 2'd2
    } t_kind;

    // Region code reported with each result.
    typedef enum logic [2:0] {
        REG_ROM_FIXED  = 3'd0,
        REG_ROM_BANKED = 3'd1,
        REG_RAM        = 3'd2,
        REG_RAM_OFF    = 3'd3,
        REG_CONTROL    = 3'd4,
        REG_UNMAPPED   = 3'd5
    } t_region;

    // Where the result byte comes from.
    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_FF   = 2'd1,
        SRC_ROM  = 2'd2,
        SRC_RAM  = 2'd3
    } t_src;

    // Access command to one memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_cmd;

    typedef logic [ROM_BANKS-1:0][ROM_IDX_W-1:0] t_rom_base_tab;
    typedef logic [RAM_BANKS-1:0][RAM_IDX_W-1:0] t_ram_base_tab;

    // Start of each ROM bank, already wrapped to the ROM size.
    function automatic t_rom_base_tab crbm_rom_base_table(input int unsigned n);
        t_rom_base_tab tab;
        int unsigned   acc;
        acc = 0;
        for (int i = 0; i < ROM_BANKS; i++) begin
            tab[i] = ROM_IDX_W'(acc);
            acc = acc + ROM_BANK_BYTES;
            if (acc >= n) begin
                acc = acc - n;
            end
        end
        return tab;
    endfunction

    // Start of each RAM bank, already wrapped to the RAM size.
    function automatic t_ram_base_tab crbm_ram_base_table(input int unsigned n);
        t_ram_base_tab tab;
        int unsigned   acc;
        acc = 0;
        for (int i = 0; i < RAM_BANKS; i++) begin
            tab[i] = RAM_IDX_W'(acc);
            acc = acc + RAM_BANK_BYTES;
            if (acc >= n) begin
                acc = acc - n;
            end
        end
        return tab;
    endfunction

endpackage

// File: design/crbm_rom.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crbm_rom
// Cartridge ROM store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module crbm_rom
    import crbm_pkg::*;
#(
    parameter  int unsigned ROM_BYTES = ROM_BYTES_DEF,
    localparam int unsigned ROM_AW    = $clog2(ROM_BYTES)
) (
    input  logic              i_clk,
    input  t_mem_cmd          i_cmd,
    input  logic [ROM_AW-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ROM_AW-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [ROM_BYTES];
    logic [7:0] r_rdata;

    // Loads write here; bus read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/crbm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crbm_ram
// Cartridge RAM store with a clearing sweep after reset.
// ---------------------------------------------------------------------------
module crbm_ram
    import crbm_pkg::*;
#(
    parameter  int unsigned RAM_BYTES = RAM_BYTES_DEF,
    localparam int unsigned RAM_AW    = $clog2(RAM_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_cmd          i_cmd,
    input  logic [RAM_AW-1:0] i_addr,
    input  logic [7:0]        i_wdata,
    output logic [7:0]        o_rdata,
    output logic              o_clr_busy
);

    logic [7:0]        r_mem [RAM_BYTES];
    logic [7:0]        r_rdata;
    logic              r_clr_busy;
    logic [RAM_AW-1:0] r_clr_addr;
    logic              w_we;
    logic [RAM_AW-1:0] w_waddr;
    logic [7:0]        w_wdata;

    // The clearing sweep owns the write port until every entry is zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == RAM_AW'(RAM_BYTES - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_comb begin
        w_we    = r_clr_busy || i_cmd.wr_en;
        w_waddr = r_clr_busy ? r_clr_addr : i_addr;
        w_wdata = r_clr_busy ? 8'h00 : i_wdata;
    end

    // Single address per cycle: a word either reads or writes.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clr_busy = r_clr_busy;

endmodule

// File: design/crbm_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crbm_ctrl
// Bus decode, bank registers, ROM load index reduction and result stages.
// ---------------------------------------------------------------------------
module crbm_ctrl
    import crbm_pkg::*;
#(
    parameter  int unsigned ROM_BYTES = ROM_BYTES_DEF,
    parameter  int unsigned RAM_BYTES = RAM_BYTES_DEF,
    localparam int unsigned ROM_AW    = $clog2(ROM_BYTES),
    localparam int unsigned RAM_AW    = $clog2(RAM_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Bus word in
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_kind,
    input  logic [15:0]       i_address,
    input  logic [7:0]        i_data_byte,
    input  logic [20:0]       i_rom_load_address,
    // Result word out
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_read_data,
    output logic [2:0]        o_region,
    // ROM port
    output t_mem_cmd          o_rom_cmd,
    output logic [ROM_AW-1:0] o_rom_waddr,
    output logic [7:0]        o_rom_wdata,
    output logic [ROM_AW-1:0] o_rom_raddr,
    input  logic [7:0]        i_rom_rdata,
    // RAM port
    output t_mem_cmd          o_ram_cmd,
    output logic [RAM_AW-1:0] o_ram_addr,
    output logic [7:0]        o_ram_wdata,
    input  logic [7:0]        i_ram_rdata,
    input  logic              i_clr_busy
);

    localparam t_rom_base_tab ROM_BASE = crbm_rom_base_table(ROM_BYTES);
    localparam t_ram_base_tab RAM_BASE = crbm_ram_base_table(RAM_BYTES);

    // Load index reduction: restoring subtraction of shifted ROM sizes.
    localparam int unsigned RED_SPAN  = (2097152 + ROM_BYTES - 1) / ROM_BYTES;
    localparam int unsigned RED_S     = $clog2(RED_SPAN);
    localparam int unsigned RED_STEPS = (RED_S < 1) ? 1 : RED_S;
    localparam int unsigned CNT_W     = $clog2(RED_STEPS + 1);
    localparam int unsigned RED_CW    = 22 + RED_STEPS;

    // Bank registers
    logic          r_ram_en,   n_ram_en;
    logic [6:0]    r_rom_bank, n_rom_bank;
    logic [1:0]    r_ram_bank, n_ram_bank;

    // Result stages
    logic          r_s1_valid;
    t_src          r_s1_src;
    t_region       r_s1_region;
    logic          r_out_valid;
    logic [7:0]    r_out_read_data;
    t_region       r_out_region;

    // Load reducer
    logic              r_red_busy;
    logic [CNT_W-1:0]  r_red_cnt;
    logic [20:0]       r_red_val;
    logic [7:0]        r_red_data;

    logic              w_accept;
    logic              w_s1_move;
    t_src              w_src;
    t_region           w_region;
    logic              w_rom_rd;
    logic              w_ram_rd;
    logic              w_ram_wr;
    logic              w_load_start;
    logic [ROM_AW-1:0] w_rom_raddr;
    logic [ROM_AW:0]   w_rom_sum;
    logic [ROM_AW-1:0] w_rom_bank_idx;
    logic [RAM_AW:0]   w_ram_sum;
    logic [RAM_AW-1:0] w_ram_idx;
    logic [CNT_W-1:0]  w_red_k;
    logic [RED_CW-1:0] w_red_cmp;
    logic              w_red_ge;
    logic [20:0]       w_red_next;
    logic              w_red_last;
    logic [7:0]        w_out_byte;

    // New word in: stage one empty or moving on, RAM clear, reducer idle.
    always_comb begin
        w_s1_move = r_s1_valid && (!r_out_valid || !i_stall);
        o_stall   = i_clr_busy || r_red_busy || (r_s1_valid && !w_s1_move);
        w_accept  = i_valid && !o_stall;
    end

    // Physical indices of the banked windows, wrapped to each store's size.
    always_comb begin
        w_rom_sum = (ROM_AW + 1)'(ROM_BASE[r_rom_bank]) + (ROM_AW + 1)'(i_address[13:0]);
        if (w_rom_sum >= (ROM_AW + 1)'(ROM_BYTES)) begin
            w_rom_bank_idx = ROM_AW'(w_rom_sum - (ROM_AW + 1)'(ROM_BYTES));
        end else begin
            w_rom_bank_idx = ROM_AW'(w_rom_sum);
        end
        w_ram_sum = (RAM_AW + 1)'(RAM_BASE[r_ram_bank]) + (RAM_AW + 1)'(i_address[12:0]);
        if (w_ram_sum >= (RAM_AW + 1)'(RAM_BYTES)) begin
            w_ram_idx = RAM_AW'(w_ram_sum - (RAM_AW + 1)'(RAM_BYTES));
        end else begin
            w_ram_idx = RAM_AW'(w_ram_sum);
        end
    end

    // Decode of the incoming word.
    always_comb begin
        n_ram_en     = r_ram_en;
        n_rom_bank   = r_rom_bank;
        n_ram_bank   = r_ram_bank;
        w_src        = SRC_ZERO;
        w_region     = REG_UNMAPPED;
        w_rom_rd     = 1'b0;
        w_ram_rd     = 1'b0;
        w_ram_wr     = 1'b0;
        w_load_start = 1'b0;
        w_rom_raddr  = w_rom_bank_idx;
        case (t_kind'(i_kind))
            KIND_READ: begin
                if (i_address <= ADDR_ROM_FIX_LAST) begin
                    w_rom_rd    = 1'b1;
                    w_rom_raddr = ROM_AW'(i_address[13:0]);
                    w_src       = SRC_ROM;
                    w_region    = REG_ROM_FIXED;
                end else if (i_address <= ADDR_ROM_BANK_LAST) begin
                    w_rom_rd = 1'b1;
                    w_src    = SRC_ROM;
                    w_region = REG_ROM_BANKED;
                end else if (i_address inside {[ADDR_RAM_FIRST:ADDR_RAM_LAST]}) begin
                    if (r_ram_en) begin
                        w_ram_rd = 1'b1;
                        w_src    = SRC_RAM;
                        w_region = REG_RAM;
                    end else begin
                        w_region = REG_RAM_OFF;
                    end
                end else begin
                    w_src = SRC_FF;
                end
            end
            KIND_WRITE: begin
                if (i_address <= ADDR_RAM_EN_LAST) begin
                    n_ram_en = (i_data_byte[3:0] == RAM_EN_KEY);
                    w_region = REG_CONTROL;
                end else if (i_address <= ADDR_ROM_FIX_LAST) begin
                    n_rom_bank = (i_data_byte[6:0] == 7'd0) ? ROM_BANK_RESET
                                                            : i_data_byte[6:0];
                    w_region   = REG_CONTROL;
                end else if (i_address <= ADDR_RAM_SEL_LAST) begin
                    // Values above the last bank are ignored.
                    if (i_data_byte <= RAM_BANK_MAX) begin
                        n_ram_bank = i_data_byte[1:0];
                    end
                    w_region = REG_CONTROL;
                end else if (i_address <= ADDR_ROM_BANK_LAST) begin
                    w_region = REG_CONTROL;
                end else if (i_address inside {[ADDR_RAM_FIRST:ADDR_RAM_LAST]}) begin
                    if (r_ram_en) begin
                        w_ram_wr = 1'b1;
                        w_region = REG_RAM;
                    end else begin
                        w_region = REG_RAM_OFF;
                    end
                end
            end
            KIND_LOAD: begin
                w_load_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Bank registers change only when a word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_en   <= 1'b0;
            r_rom_bank <= ROM_BANK_RESET;
            r_ram_bank <= 2'd0;
        end else if (w_accept) begin
            r_ram_en   <= n_ram_en;
            r_rom_bank <= n_rom_bank;
            r_ram_bank <= n_ram_bank;
        end
    end

    // One reduction step per cycle; the last step writes the byte.
    always_comb begin
        w_red_k    = r_red_cnt - 1'b1;
        w_red_cmp  = RED_CW'(ROM_BYTES) << w_red_k;
        w_red_ge   = RED_CW'(r_red_val) >= w_red_cmp;
        w_red_next = w_red_ge ? 21'(RED_CW'(r_red_val) - w_red_cmp) : r_red_val;
        w_red_last = r_red_busy && (r_red_cnt == CNT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_busy <= 1'b0;
            r_red_cnt  <= '0;
        end else if (w_accept && w_load_start) begin
            r_red_busy <= 1'b1;
            r_red_cnt  <= CNT_W'(RED_STEPS);
        end else if (r_red_busy) begin
            r_red_cnt <= r_red_cnt - 1'b1;
            if (w_red_last) begin
                r_red_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_load_start) begin
            r_red_val  <= i_rom_load_address;
            r_red_data <= i_data_byte;
        end else if (r_red_busy) begin
            r_red_val <= w_red_next;
        end
    end

    // Memory commands.
    always_comb begin
        o_rom_cmd.rd_en = w_accept && w_rom_rd;
        o_rom_cmd.wr_en = w_red_last;
        o_rom_raddr     = w_rom_raddr;
        o_rom_waddr     = ROM_AW'(w_red_next);
        o_rom_wdata     = r_red_data;
        o_ram_cmd.rd_en = w_accept && w_ram_rd;
        o_ram_cmd.wr_en = w_accept && w_ram_wr;
        o_ram_addr      = w_ram_idx;
        o_ram_wdata     = i_data_byte;
    end

    // Stage one waits for the memory read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_src    <= w_src;
            r_s1_region <= w_region;
        end
    end

    // Result byte selection.
    always_comb begin
        case (r_s1_src)
            SRC_ROM: w_out_byte = i_rom_rdata;
            SRC_RAM: w_out_byte = i_ram_rdata;
            SRC_FF:  w_out_byte = UNMAPPED_BYTE;
            default: w_out_byte = 8'h00;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_read_data <= w_out_byte;
            r_out_region    <= r_s1_region;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_read_data;
    assign o_region    = r_out_region;

    // The bank mapping never selects bank zero in the switchable window.
    a_rom_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rom_bank != 7'd0)
        else $error("ROM bank register holds zero");

    // The clearing sweep has the RAM to itself.
    a_no_ram_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr_busy |-> !(o_ram_cmd.rd_en || o_ram_cmd.wr_en))
        else $error("RAM accessed during clearing sweep");

    // Wrapped RAM index stays inside the store.
    a_ram_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram_cmd.rd_en || o_ram_cmd.wr_en) |->
            ({1'b0, o_ram_addr} < (RAM_AW + 1)'(RAM_BYTES)))
        else $error("RAM index out of range");

    // A taken load word starts the index reduction.
    a_load_starts_reducer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_load_start) |=> r_red_busy)
        else $error("Load word did not start reduction");

    // A held word in stage one is not lost.
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_move) |=> r_s1_valid)
        else $error("Stage one word dropped");

endmodule

// File: design/cartridge_rom_ram_bank_mapper.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cartridge_rom_ram_bank_mapper
// ROM/RAM bank mapper for a cartridge bus: reads, control and RAM writes, ROM
// loads, with ROM and RAM held in synchronous memories.
//
//   Channel  Direction  Handshake          Payload
//   bus in   input      i_valid / o_stall  i_kind, i_address, i_data_byte,
//                                          i_rom_load_address
//   result   output     o_valid / i_stall  o_read_data, o_region
//
// A word is taken at an edge with valid high and stall low; its result is
// registered in stage one, where the memory read data arrives, and then in
// the output register that drives o_valid. Reads and writes go one per cycle
// while the result is not stalled, set by the single memory access per word.
// A ROM load holds the input while the load index is reduced to the ROM size
// by shifted subtraction. After reset the RAM is zeroed, and o_stall stays
// high during the sweep. A stalled result stops stage one, and then the input.
// ---------------------------------------------------------------------------
module cartridge_rom_ram_bank_mapper
    import crbm_pkg::*;
#(
    parameter int unsigned ROM_BYTES = ROM_BYTES_DEF,
    parameter int unsigned RAM_BYTES = RAM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data_byte,
    input  logic [20:0] i_rom_load_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic [2:0]  o_region
);

    localparam int unsigned ROM_AW = $clog2(ROM_BYTES);
    localparam int unsigned RAM_AW = $clog2(RAM_BYTES);

    t_mem_cmd          w_rom_cmd;
    logic [ROM_AW-1:0] w_rom_waddr;
    logic [7:0]        w_rom_wdata;
    logic [ROM_AW-1:0] w_rom_raddr;
    logic [7:0]        w_rom_rdata;
    t_mem_cmd          w_ram_cmd;
    logic [RAM_AW-1:0] w_ram_addr;
    logic [7:0]        w_ram_wdata;
    logic [7:0]        w_ram_rdata;
    logic              w_clr_busy;

    // Decode, bank registers and result stages.
    crbm_ctrl #(
        .ROM_BYTES (ROM_BYTES),
        .RAM_BYTES (RAM_BYTES)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_kind             (i_kind),
        .i_address          (i_address),
        .i_data_byte        (i_data_byte),
        .i_rom_load_address (i_rom_load_address),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_read_data        (o_read_data),
        .o_region           (o_region),
        .o_rom_cmd          (w_rom_cmd),
        .o_rom_waddr        (w_rom_waddr),
        .o_rom_wdata        (w_rom_wdata),
        .o_rom_raddr        (w_rom_raddr),
        .i_rom_rdata        (w_rom_rdata),
        .o_ram_cmd          (w_ram_cmd),
        .o_ram_addr         (w_ram_addr),
        .o_ram_wdata        (w_ram_wdata),
        .i_ram_rdata        (w_ram_rdata),
        .i_clr_busy         (w_clr_busy)
    );

    // ROM store.
    crbm_rom #(
        .ROM_BYTES (ROM_BYTES)
    ) u_rom (
        .i_clk   (i_clk),
        .i_cmd   (w_rom_cmd),
        .i_waddr (w_rom_waddr),
        .i_wdata (w_rom_wdata),
        .i_raddr (w_rom_raddr),
        .o_rdata (w_rom_rdata)
    );

    // RAM store with its clearing sweep.
    crbm_ram #(
        .RAM_BYTES (RAM_BYTES)
    ) u_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_ram_cmd),
        .i_addr     (w_ram_addr),
        .i_wdata    (w_ram_wdata),
        .o_rdata    (w_ram_rdata),
        .o_clr_busy (w_clr_busy)
    );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the cartridge bank mapper. A directed table covers
// reset state, region edges, bank masking and ignored writes. It is followed
// by random sessions of ROM loads with read-back, RAM enable/select/write/read
// sequences and noise. Each word is checked against a pinned table result or
// the shadow mapper, with random sender bursts and random result stalls.
// ---------------------------------------------------------------------------
module tb;
    import crbm_pkg::*;

    localparam int unsigned ROM_SZ     = ROM_BYTES_DEF;
    localparam int unsigned RAM_SZ     = RAM_BYTES_DEF;
    localparam logic [1:0]  KIND_SPARE = 2'd3;
    localparam int          N_RANDOM   = 1700;
    localparam int          CYCLE_CAP  = 600000;
    localparam int          DRAIN_STEP = 300;

    // One expected result.
    typedef struct {
        logic [7:0] rd;
        t_region    region;
    } t_result;

    // One row of the directed table; rd and region are used only when pinned.
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [20:0] ld;
        bit          pinned;
        logic [7:0]  rd;
        t_region     region;
    } t_bus_row;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_valid            = 1'b0;
    logic [1:0]  i_kind             = 2'd0;
    logic [15:0] i_address          = 16'd0;
    logic [7:0]  i_data_byte        = 8'd0;
    logic [20:0] i_rom_load_address = 21'd0;
    logic        i_stall            = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_read_data;
    logic [2:0]  o_region;

    // Shadow state of the mapper.
    logic [7:0]  rom_img [int unsigned];
    logic [7:0]  ram_img [RAM_SZ];
    logic        sh_ram_on;
    logic [6:0]  sh_rom_bank;
    logic [1:0]  sh_ram_bank;

    t_result     results_due [$];
    int unsigned rom_loaded [$];
    int          words_sent  = 0;
    int          burst_left  = 0;
    int          mismatches  = 0;
    int          cycles      = 0;
    int          stall_left  = 0;
    int unsigned stall_mode  = 0;
    t_result     got;

    // Directed stimulus: reset state, region edges, masking and ignored writes.
    t_bus_row dir_rows [31] = '{
        '{KIND_READ,  16'hA000, 8'h00, 21'h000000, 1'b1, 8'h00, REG_RAM_OFF},
        '{KIND_READ,  16'h8000, 8'h00, 21'h000000, 1'b1, 8'hFF, REG_UNMAPPED},
        '{KIND_READ,  16'hFFFF, 8'h00, 21'h000000, 1'b1, 8'hFF, REG_UNMAPPED},
        '{KIND_SPARE, 16'h4000, 8'hAB, 21'h000000, 1'b1, 8'h00, REG_UNMAPPED},
        '{KIND_WRITE, 16'hA000, 8'h55, 21'h000000, 1'b1, 8'h00, REG_RAM_OFF},
        '{KIND_LOAD,  16'h0000, 8'h12, 21'h000000, 1'b1, 8'h00, REG_UNMAPPED},
        '{KIND_LOAD,  16'hFFFF, 8'hFF, 21'h1FFFFF, 1'b1, 8'h00, REG_UNMAPPED},
        '{KIND_LOAD,  16'h0000, 8'hA5, 21'h003FFF, 1'b0, 8'h00, REG_UNMAPPED},
        '{KIND_READ,  16'h0000, 8'h00, 21'h000000, 1'b1, 8'h12, REG_ROM_FIXED},
        '{KIND_READ,  16'h3FFF, 8'h00, 21'h000000, 1'b1, 8'hA5, REG_ROM_FIXED},
        '{KIND_LOAD,  16'h0000, 8'h5A, 21'h004000, 1'b0, 8'h00, REG_UNMAPPED},
        '{KIND_READ,  16'h4000, 8'h00, 21'h000000, 1'b1, 8'h5A, REG_ROM_BANKED},
        '{KIND_WRITE, 16'h2000, 8'h00, 21'h000000, 1'b1, 8'h00, REG_CONTROL},
        '{KIND_READ,  16'h4000, 8'h00, 21'h000000, 1'b0, 8'h00, REG_UNMAPPED},
        '{KIND_WRITE, 16'h3FFF, 8'hFF, 21'h000000, 1'b1, 8'h00, REG_CONTROL},
        '{KIND_READ,  16'h7FFF, 8'h00, 21'h000000, 1'b1, 8'hFF, REG_ROM_BANKED},
        '{KIND_WRITE, 16'h2000, 8'h80, 21'h000000, 1'b0, 8'h00, REG_UNMAPPED},
        '{KIND_READ,  16'h4000, 8'h00, 21'h000000, 1'b0, 8'h00, REG_UNMAPPED},
        '{KIND_WRITE, 16'h0000, 8'hFA, 21'h000000, 1'b1, 8'h00, REG_CONTROL},
        '{KIND_READ,  16'hA000, 8'h00, 21'h000000, 1'b1, 8'h00, REG_RAM},
        '{KIND_WRITE, 16'hBFFF, 8'hFF, 21'h000000, 1'b0, 8'h00, REG_UNMAPPED},
        '{KIND_READ,  16'hBFFF, 8'h00, 21'h000000, 1'b0, 8'h00, REG_UNMAPPED},
        '{KIND_WRITE, 16'h4000, 8'h03, 21'h000000, 1'b0, 8'h00, REG_UNMAPPED},
        '{KIND_WRITE, 16'h5FFF, 8'h08, 21'h000000, 1'b0, 8'h00, REG_UNMAPPED},
        '{KIND_WRITE, 16'hA000, 8'h77, 21'h000000, 1'b0, 8'h00, REG_UNMAPPED},
        '{KIND_READ,  16'hA000, 8'h00, 21'h000000, 1'b0, 8'h00, REG_UNMAPPED},
        '{KIND_READ,  16'hBFFF, 8'h00, 21'h000000, 1'b0, 8'h00, REG_UNMAPPED},
        '{KIND_WRITE, 16'h6000, 8'h5C, 21'h000000, 1'b1, 8'h00, REG_CONTROL},
        '{KIND_WRITE, 16'h1FFF, 8'h0B, 21'h000000, 1'b0, 8'h00, REG_UNMAPPED},
        '{KIND_READ,  16'hBFFF, 8'h00, 21'h000000, 1'b1, 8'h00, REG_RAM_OFF},
        '{KIND_WRITE, 16'hC000, 8'h99, 21'h000000, 1'b1, 8'h00, REG_UNMAPPED}
    };

    cartridge_rom_ram_bank_mapper u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_kind             (i_kind),
        .i_address          (i_address),
        .i_data_byte        (i_data_byte),
        .i_rom_load_address (i_rom_load_address),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_read_data        (o_read_data),
        .o_region           (o_region)
    );

    always #1 i_clk = ~i_clk;

    // Physical ROM index that a bus address in 0x0000-0x7FFF reaches now.
    function automatic int unsigned rom_phys(input logic [15:0] a);
        if (a <= ADDR_ROM_FIX_LAST) begin
            return 32'(a) % ROM_SZ;
        end
        return (32'(sh_rom_bank) * ROM_BANK_BYTES + 32'(a) - ROM_BANK_BYTES) % ROM_SZ;
    endfunction

    // Physical RAM index of a bus address in 0xA000-0xBFFF.
    function automatic int unsigned ram_phys(input logic [15:0] a);
        return (32'(sh_ram_bank) * RAM_BANK_BYTES + 32'(a - ADDR_RAM_FIRST)) % RAM_SZ;
    endfunction

    // Applies one bus word to the shadow state and returns its result.
    function automatic t_result mapper_access(input logic [1:0] k, input logic [15:0] a,
                                              input logic [7:0] d, input logic [20:0] l);
        t_result r;
        r.rd     = 8'h00;
        r.region = REG_UNMAPPED;
        if (k == KIND_READ) begin
            if (a <= ADDR_ROM_FIX_LAST) begin
                r.rd     = rom_img[rom_phys(a)];
                r.region = REG_ROM_FIXED;
            end else if (a <= ADDR_ROM_BANK_LAST) begin
                r.rd     = rom_img[rom_phys(a)];
                r.region = REG_ROM_BANKED;
            end else if (a >= ADDR_RAM_FIRST && a <= ADDR_RAM_LAST) begin
                if (sh_ram_on) begin
                    r.rd     = ram_img[ram_phys(a)];
                    r.region = REG_RAM;
                end else begin
                    r.region = REG_RAM_OFF;
                end
            end else begin
                r.rd = UNMAPPED_BYTE;
            end
        end else if (k == KIND_WRITE) begin
            if (a <= ADDR_RAM_EN_LAST) begin
                sh_ram_on = (d[3:0] == RAM_EN_KEY);
                r.region  = REG_CONTROL;
            end else if (a <= ADDR_ROM_FIX_LAST) begin
                sh_rom_bank = (d[6:0] == 7'd0) ? ROM_BANK_RESET : d[6:0];
                r.region    = REG_CONTROL;
            end else if (a <= ADDR_RAM_SEL_LAST) begin
                if (d <= RAM_BANK_MAX) begin
                    sh_ram_bank = d[1:0];
                end
                r.region = REG_CONTROL;
            end else if (a <= ADDR_ROM_BANK_LAST) begin
                r.region = REG_CONTROL;
            end else if (a >= ADDR_RAM_FIRST && a <= ADDR_RAM_LAST) begin
                if (sh_ram_on) begin
                    ram_img[ram_phys(a)] = d;
                    r.region = REG_RAM;
                end else begin
                    r.region = REG_RAM_OFF;
                end
            end
        end else if (k == KIND_LOAD) begin
            rom_img[32'(l) % ROM_SZ] = d;
            rom_loaded.push_back(32'(l) % ROM_SZ);
        end
        return r;
    endfunction

    // Presents one word, waits for it to be taken and records its result.
    task automatic send_word(input logic [1:0] k, input logic [15:0] a, input logic [7:0] d,
                             input logic [20:0] l, input bit pinned = 1'b0,
                             input logic [7:0] p_rd = 8'h00,
                             input t_region p_region = REG_UNMAPPED);
        t_result r;
        // A ROM read of a byte never loaded becomes a load of that byte.
        if (k == KIND_READ && a <= ADDR_ROM_BANK_LAST && !rom_img.exists(rom_phys(a))) begin
            k = KIND_LOAD;
            l = 21'(rom_phys(a));
        end
        r = mapper_access(k, a, d, l);
        if (pinned) begin
            r.rd     = p_rd;
            r.region = p_region;
        end
        // Sender bursts with random gaps between them.
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        i_valid            <= 1'b1;
        i_kind             <= k;
        i_address          <= a;
        i_data_byte        <= d;
        i_rom_load_address <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        results_due.push_back(r);
        words_sent++;
    endtask

    // Holds the sender off until every outstanding result has arrived.
    task automatic drain_results();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    // Reads back a loaded ROM byte, switching bank first where needed.
    task automatic rom_read_back(input int unsigned idx);
        logic [6:0] bank;
        bank = idx[20:14];
        if (bank == 7'd0) begin
            send_word(KIND_READ, {2'b00, idx[13:0]}, 8'($urandom), 21'($urandom));
        end else begin
            if (bank != sh_rom_bank) begin
                send_word(KIND_WRITE, 16'h2000 | 16'($urandom_range(0, 16'h1FFF)),
                          {1'($urandom), bank}, 21'($urandom));
            end
            send_word(KIND_READ, {2'b01, idx[13:0]}, 8'($urandom), 21'($urandom));
        end
    endtask

    // Loads a random ROM byte and reads it straight back.
    task automatic rom_session();
        int unsigned idx;
        case ($urandom_range(0, 9))
            0, 1, 2: idx = $urandom_range(0, 16'h3FFF);
            3:       idx = ROM_SZ - 1 - $urandom_range(0, 16'h3FFF);
            default: idx = $urandom() & (ROM_SZ - 1);
        endcase
        send_word(KIND_LOAD, 16'($urandom), 8'($urandom), 21'(idx));
        rom_read_back(idx);
    endtask

    // Enables RAM, picks a bank, writes a few bytes and reads them back.
    task automatic ram_session();
        logic [12:0] offs [$];
        logic [12:0] off;
        logic [7:0]  d;
        send_word(KIND_WRITE, 16'($urandom_range(0, 16'h1FFF)),
                  {4'($urandom), RAM_EN_KEY}, 21'($urandom));
        d = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        send_word(KIND_WRITE, 16'h4000 | 16'($urandom_range(0, 16'h1FFF)), d,
                  21'($urandom));
        repeat ($urandom_range(1, 6)) begin
            off = 13'($urandom);
            offs.push_back(off);
            send_word(KIND_WRITE, ADDR_RAM_FIRST | {3'b000, off}, 8'($urandom),
                      21'($urandom));
        end
        foreach (offs[i]) begin
            send_word(KIND_READ, ADDR_RAM_FIRST | {3'b000, offs[i]}, 8'($urandom),
                      21'($urandom));
        end
        send_word(KIND_READ, ADDR_RAM_FIRST | 16'($urandom_range(0, 16'h1FFF)),
                  8'($urandom), 21'($urandom));
        // Now and then switch RAM off and show that it reads as disabled.
        if ($urandom_range(0, 3) == 0) begin
            d = 8'($urandom);
            if (d[3:0] == RAM_EN_KEY) begin
                d[0] = ~d[0];
            end
            send_word(KIND_WRITE, 16'($urandom_range(0, 16'h1FFF)), d, 21'($urandom));
            send_word(KIND_WRITE, ADDR_RAM_FIRST | 16'($urandom_range(0, 16'h1FFF)),
                      8'($urandom), 21'($urandom));
            send_word(KIND_READ, ADDR_RAM_FIRST | 16'($urandom_range(0, 16'h1FFF)),
                      8'($urandom), 21'($urandom));
        end
    endtask

    // Main sequence: reset, directed table, random sessions, then the wind-down.
    initial begin
        int next_drain;
        int stop_at;
        sh_ram_on   = 1'b0;
        sh_rom_bank = ROM_BANK_RESET;
        sh_ram_bank = 2'd0;
        foreach (ram_img[i]) ram_img[i] = 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].kind, dir_rows[i].addr, dir_rows[i].data, dir_rows[i].ld,
                      dir_rows[i].pinned, dir_rows[i].rd, dir_rows[i].region);
        end
        drain_results();

        stop_at    = words_sent + N_RANDOM;
        next_drain = words_sent + DRAIN_STEP;
        while (words_sent < stop_at) begin
            case ($urandom_range(0, 99)) inside
                [0:24]:  rom_session();
                [25:49]: ram_session();
                [50:69]: rom_read_back(rom_loaded[$urandom_range(0, rom_loaded.size() - 1)]);
                default: send_word(2'($urandom), 16'($urandom), 8'($urandom),
                                   21'($urandom));
            endcase
            if (words_sent >= next_drain) begin
                drain_results();
                next_drain = words_sent + DRAIN_STEP;
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Receiver stall pattern: runs of no stall, light, heavy and periodic stalling.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 99) < 30);
            2:       i_stall <= ($urandom_range(0, 99) < 75);
            default: i_stall <= (stall_left[2:0] < 3'd3);
        endcase
    end

    // Result checker: each word taken from the block is matched to the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (results_due.size() == 0) begin
                $error("unexpected word: read_data %02h region %0d", o_read_data, o_region);
                mismatches++;
            end else begin
                got = results_due.pop_front();
                if (o_read_data !== got.rd) begin
                    $error("read_data: expected %02h, got %02h", got.rd, o_read_data);
                    mismatches++;
                end
                if (o_region !== got.region) begin
                    $error("region: expected %0d, got %0d", got.region, o_region);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the whole run, including the RAM clearing pass after reset.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule
